/* src/ltc_pkg.sv */
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int CHANNELS   = 5;
    localparam int HIST_W     = 3;
    localparam int VOTE_MIN   = 2;
    localparam int COUNT_W    = 3;
    localparam int WEIGHT_W   = 13;
    localparam int DEV_W      = 14;
    localparam int SUM_W      = 16;
    localparam int LIMIT_W    = 16;
    localparam int TICKS_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // ceil(2^16 / 3); exact floor division by three for magnitudes below 2^15.
    localparam logic [31:0] RECIP3 = 32'd21846;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_INVERT   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ABN_LIMIT    = 8'd7;

    // Weights -200, -100, 0, 100, 200 for channels 0 to 4.
    localparam logic [CHANNELS-1:0][WEIGHT_W-1:0] WEIGHT_RESET =
        {13'h00C8, 13'h0064, 13'h0000, 13'h1F9C, 13'h1F38};
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd200;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LOST    = 2'd1,
        ST_ALL     = 2'd2,
        ST_SUSPECT = 2'd3
    } ltc_status_t;

    typedef struct packed {
        logic [CHANNELS-1:0] mask;
        logic [COUNT_W-1:0]  count;
    } ltc_item_t;

    typedef struct packed {
        logic [CHANNELS-1:0][WEIGHT_W-1:0] weight;
        logic                              invert;
        logic [LIMIT_W-1:0]                limit;
    } ltc_cfg_t;

endpackage

/* src/ltc_front.sv */
`timescale 1ns / 1ps

module ltc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ltc_pkg::CHANNELS-1:0]  raw_levels,
    input  logic                          active_level,
    input  logic                          q_full,
    output logic                          q_push,
    output ltc_pkg::ltc_item_t            q_item
);

    logic [ltc_pkg::CHANNELS-1:0][ltc_pkg::HIST_W-1:0] hist_reg;
    logic [ltc_pkg::CHANNELS-1:0][ltc_pkg::HIST_W-1:0] hist_next;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        logic [ltc_pkg::COUNT_W-1:0] cnt;
        logic [1:0]                  ones;
        cnt = '0;
        for (int i = 0; i < ltc_pkg::CHANNELS; i++)
        begin
            hist_next[i] = {hist_reg[i][ltc_pkg::HIST_W-2:0],
                            raw_levels[i] == active_level};
            ones = 2'(hist_next[i][0]) + 2'(hist_next[i][1]) + 2'(hist_next[i][2]);
            q_item.mask[i] = (ones >= 2'(ltc_pkg::VOTE_MIN));
            cnt = cnt + ltc_pkg::COUNT_W'(q_item.mask[i]);
        end
        q_item.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (q_push)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

/* src/ltc_queue.sv */
`timescale 1ns / 1ps

module ltc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ltc_pkg::ltc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output ltc_pkg::ltc_item_t pop_item
);

    ltc_pkg::ltc_item_t                mem_reg [ltc_pkg::QDEPTH];
    logic [ltc_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [ltc_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [ltc_pkg::QCNT_W-1:0]        cnt_reg;
    logic [ltc_pkg::QCNT_W-1:0]        cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign full      = (cnt_reg == ltc_pkg::QCNT_W'(ltc_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ltc_pkg::QPTR_W'(ltc_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ltc_pkg::QPTR_W'(ltc_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* src/ltc_back.sv */
`timescale 1ns / 1ps

module ltc_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ltc_pkg::ltc_cfg_t                 cfg,
    input  logic                              q_not_empty,
    input  ltc_pkg::ltc_item_t                q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ltc_pkg::DEV_W-1:0]  deviation,
    output logic [ltc_pkg::CHANNELS-1:0]      active_mask,
    output logic [ltc_pkg::COUNT_W-1:0]       active_count,
    output logic [1:0]                        track_status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    ltc_pkg::ltc_item_t                 item_reg;
    logic signed [ltc_pkg::SUM_W-1:0]   sum_reg;
    logic signed [ltc_pkg::SUM_W-1:0]   sum_next;
    logic [ltc_pkg::SUM_W-2:0]          quo_reg;
    logic [ltc_pkg::SUM_W-2:0]          quo_next;
    logic                               neg_reg;
    logic signed [ltc_pkg::DEV_W-1:0]   last_good_reg;
    logic [ltc_pkg::TICKS_W-1:0]        ticks_reg;
    logic [ltc_pkg::TICKS_W-1:0]        ticks_next;
    logic signed [ltc_pkg::DEV_W-1:0]   dev_next;
    ltc_pkg::ltc_status_t               status_next;
    logic                               partial;
    logic                               out_valid_reg;
    logic signed [ltc_pkg::DEV_W-1:0]   deviation_reg;
    logic [ltc_pkg::CHANNELS-1:0]       mask_reg;
    logic [ltc_pkg::COUNT_W-1:0]        count_reg;
    ltc_pkg::ltc_status_t               status_reg;
    logic                               load_out;

    assign out_valid    = out_valid_reg;
    assign deviation    = deviation_reg;
    assign active_mask  = mask_reg;
    assign active_count = count_reg;
    assign track_status = status_reg;

    assign q_pop    = (state_reg == S_IDLE) && q_not_empty;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_not_empty) state_next = S_SUM;
            S_SUM:  state_next = S_DIV;
            S_DIV:  state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Masked weight sum, negated when the direction is inverted.
    always_comb
    begin
        logic signed [ltc_pkg::SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < ltc_pkg::CHANNELS; i++)
        begin
            if (item_reg.mask[i])
            begin
                acc = acc + ltc_pkg::SUM_W'(signed'(cfg.weight[i]));
            end
        end
        sum_next = cfg.invert ? -acc : acc;
    end

    // Magnitude divided by the active count (one to four); truncates toward zero.
    always_comb
    begin
        logic [ltc_pkg::SUM_W-1:0] neg_sum;
        logic [ltc_pkg::SUM_W-2:0] mag;
        logic [31:0]               prod;
        neg_sum = -sum_reg;
        mag     = sum_reg[ltc_pkg::SUM_W-1] ? neg_sum[ltc_pkg::SUM_W-2:0]
                                            : sum_reg[ltc_pkg::SUM_W-2:0];
        prod    = 32'(mag) * ltc_pkg::RECIP3;
        case (item_reg.count)
            3'd2:    quo_next = mag >> 1;
            3'd3:    quo_next = prod[30:16];
            3'd4:    quo_next = mag >> 2;
            default: quo_next = mag;
        endcase
    end

    always_comb
    begin
        logic [ltc_pkg::SUM_W-2:0] signed_quo;
        signed_quo = neg_reg ? -quo_reg : quo_reg;
        partial    = 1'b0;
        if (item_reg.count == '0)
        begin
            status_next = ltc_pkg::ST_LOST;
            dev_next    = last_good_reg;
        end
        else if (item_reg.count == ltc_pkg::COUNT_W'(ltc_pkg::CHANNELS))
        begin
            status_next = ltc_pkg::ST_ALL;
            dev_next    = '0;
        end
        else
        begin
            status_next = ltc_pkg::ST_OK;
            dev_next    = signed_quo[ltc_pkg::DEV_W-1:0];
            partial     = 1'b1;
        end
        if (partial)
        begin
            ticks_next = '0;
        end
        else
        begin
            ticks_next = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
        end
        if (ticks_next > cfg.limit)
        begin
            status_next = ltc_pkg::ST_SUSPECT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == S_DIV)
        begin
            quo_reg <= quo_next;
            neg_reg <= sum_reg[ltc_pkg::SUM_W-1];
        end
        if (load_out)
        begin
            deviation_reg <= dev_next;
            mask_reg      <= item_reg.mask;
            count_reg     <= item_reg.count;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_good_reg <= '0;
            ticks_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                ticks_reg     <= ticks_next;
                if (partial)
                begin
                    last_good_reg <= dev_next;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* src/line_tracker_centroid.sv */
`timescale 1ns / 1ps

// Five-channel line tracker. Each input transaction carries one tick of raw
// sensor levels and yields exactly one result transaction with the debounced
// mask, its count, a weighted-centroid deviation and a track status. The
// front end debounces and queues a tick in the cycle it is accepted, so input
// is taken whenever the two-entry queue has room; the back end then takes
// each tick through queue pop, weight sum, divide by the active count and
// result register load, and pops the next tick only once that result is
// loaded, which a stalled output holds off. Configuration writes are always
// ready and should only be issued while no tick is in flight.
module line_tracker_centroid
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ltc_pkg::CHANNELS-1:0]        raw_levels,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ltc_pkg::DEV_W-1:0]    deviation,
    output logic [ltc_pkg::CHANNELS-1:0]        active_mask,
    output logic [ltc_pkg::COUNT_W-1:0]         active_count,
    output logic [1:0]                          track_status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ltc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ltc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ltc_pkg::ltc_cfg_t  cfg_reg;
    logic               active_level_reg;
    logic               q_full;
    logic               q_push;
    logic               q_not_empty;
    logic               q_pop;
    ltc_pkg::ltc_item_t push_item;
    ltc_pkg::ltc_item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight   <= ltc_pkg::WEIGHT_RESET;
            cfg_reg.invert   <= 1'b0;
            cfg_reg.limit    <= ltc_pkg::LIMIT_RESET;
            active_level_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index < ltc_pkg::REG_DIR_INVERT)
            begin
                cfg_reg.weight[cfg_index[2:0]] <= cfg_data[ltc_pkg::WEIGHT_W-1:0];
            end
            else if (cfg_index == ltc_pkg::REG_DIR_INVERT)
            begin
                cfg_reg.invert <= cfg_data[0];
            end
            else if (cfg_index == ltc_pkg::REG_ACTIVE_LEVEL)
            begin
                active_level_reg <= cfg_data[0];
            end
            else if (cfg_index == ltc_pkg::REG_ABN_LIMIT)
            begin
                cfg_reg.limit <= cfg_data[ltc_pkg::LIMIT_W-1:0];
            end
        end
    end

    ltc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_levels   (raw_levels),
        .active_level (active_level_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    ltc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    ltc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_not_empty  (q_not_empty),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .deviation    (deviation),
        .active_mask  (active_mask),
        .active_count (active_count),
        .track_status (track_status)
    );

endmodule

/* src/ltc_checker.sv */
`timescale 1ns / 1ps

module ltc_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [ltc_pkg::DEV_W-1:0]    deviation,
    input  logic [ltc_pkg::CHANNELS-1:0]        active_mask,
    input  logic [ltc_pkg::COUNT_W-1:0]         active_count,
    input  logic [1:0]                          track_status
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(deviation)
                                   && $stable(active_mask) && $stable(track_status))
        else $error("result changed while stalled");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones(active_mask) == int'(active_count))
        else $error("active count does not match mask");

    a_all_zero_dev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && track_status == ltc_pkg::ST_ALL |-> active_mask == '1 && deviation == '0)
        else $error("all-active result with bad mask or deviation");

    a_lost_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && track_status == ltc_pkg::ST_LOST |-> active_mask == '0)
        else $error("lost result with active channels");

    a_ok_partial: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && track_status == ltc_pkg::ST_OK
            |-> active_count != '0 && active_count != ltc_pkg::COUNT_W'(ltc_pkg::CHANNELS))
        else $error("ok status without partial activity");

endmodule

bind line_tracker_centroid ltc_checker u_ltc_checker (.*);

/* dv/line_tracker_centroid_tb.sv */
`timescale 1ns / 1ps

module line_tracker_centroid_tb;
    import ltc_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int MAX_PRINTED  = 100;
    localparam int ABNORMAL_RUN = 24;

    typedef struct {
        logic signed [DEV_W-1:0] dev;
        logic [CHANNELS-1:0]     mask;
        logic [COUNT_W-1:0]      count;
        ltc_status_t             status;
    } tick_reading_t;

    // Tracks the sensor state and configuration and predicts one reading per tick.
    class centroid_tracker_model;
        logic signed [WEIGHT_W-1:0] weight [CHANNELS];
        logic                       invert;
        logic                       level_on;
        logic [LIMIT_W-1:0]         limit;
        logic [HIST_W-1:0]          history [CHANNELS];
        logic signed [DEV_W-1:0]    held_dev;
        logic [TICKS_W-1:0]         abnormal;
        tick_reading_t              expected_readings [$];
        int                         mismatches;

        function new();
            weight[0] = -13'sd200;
            weight[1] = -13'sd100;
            weight[2] = 13'sd0;
            weight[3] = 13'sd100;
            weight[4] = 13'sd200;
            invert = 1'b0;
            level_on = 1'b1;
            limit = LIMIT_RESET;
            foreach (history[i])
                history[i] = '0;
            held_dev = '0;
            abnormal = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (int'(idx) - int'(REG_WEIGHT_ONE) < CHANNELS)
                weight[int'(idx) - int'(REG_WEIGHT_ONE)] = data[WEIGHT_W-1:0];
            else if (idx == REG_DIR_INVERT)
                invert = data[0];
            else if (idx == REG_ACTIVE_LEVEL)
                level_on = data[0];
            else if (idx == REG_ABN_LIMIT)
                limit = data[LIMIT_W-1:0];
        endfunction

        function void note_tick(logic [CHANNELS-1:0] levels);
            logic [HIST_W-1:0] h;
            tick_reading_t     r;
            int                count;
            int                sum;
            r.mask = '0;
            count = 0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                h = {history[i][HIST_W-2:0], levels[i] == level_on};
                history[i] = h;
                if (int'(h[0]) + int'(h[1]) + int'(h[2]) >= VOTE_MIN)
                begin
                    r.mask[i] = 1'b1;
                    count++;
                end
            end
            r.count = COUNT_W'(count);
            if (count == 0)
            begin
                r.status = ST_LOST;
                if (abnormal != '1)
                    abnormal++;
                r.dev = held_dev;
            end
            else if (count == CHANNELS)
            begin
                r.status = ST_ALL;
                if (abnormal != '1)
                    abnormal++;
                r.dev = '0;
            end
            else
            begin
                sum = 0;
                for (int i = 0; i < CHANNELS; i++)
                    if (r.mask[i])
                        sum += weight[i];
                if (invert)
                    sum = -sum;
                // Integer division truncates toward zero, as the centroid requires.
                r.dev = DEV_W'(sum / count);
                held_dev = r.dev;
                r.status = ST_OK;
                abnormal = '0;
            end
            if (abnormal > limit)
                r.status = ST_SUSPECT;
            expected_readings.push_back(r);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_reading(logic signed [DEV_W-1:0] dev, logic [CHANNELS-1:0] mask,
                                    logic [COUNT_W-1:0] count, logic [1:0] status);
            tick_reading_t r;
            if (expected_readings.size() == 0)
            begin
                report($sformatf("unexpected reading: expected none, got dev %0d mask %b",
                                 dev, mask));
                return;
            end
            r = expected_readings.pop_front();
            if (r.dev !== dev)
                report($sformatf("deviation: expected %0d, got %0d", r.dev, dev));
            if (r.mask !== mask)
                report($sformatf("active_mask: expected %b, got %b", r.mask, mask));
            if (r.count !== count)
                report($sformatf("active_count: expected %0d, got %0d", r.count, count));
            if (2'(r.status) !== status)
                report($sformatf("track_status: expected %0d, got %0d", 2'(r.status), status));
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [CHANNELS-1:0]           raw_levels;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [DEV_W-1:0]       deviation;
    logic [CHANNELS-1:0]           active_mask;
    logic [COUNT_W-1:0]            active_count;
    logic [1:0]                    track_status;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    centroid_tracker_model tracker = new();
    logic hold_req = 1'b0;
    bit   back_to_back;
    bit   free_run;
    int   burst_left;
    int   cycles = 0;

    line_tracker_centroid dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_levels   (raw_levels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .deviation    (deviation),
        .active_mask  (active_mask),
        .active_count (active_count),
        .track_status (track_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("line_tracker_centroid_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_tick(raw_levels);
            if (out_valid && !out_stall)
                tracker.check_reading(deviation, active_mask, active_count, track_status);
        end
    end

    // Output side: a stall pattern that changes density now and then, plus a long
    // hold-off on request so that the queue fills and the input gets stalled.
    initial
    begin : receiver
        int hold_left;
        int stall_pct;
        int pattern_left;
        hold_left = 0;
        stall_pct = 0;
        pattern_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = 150;
                hold_req <= 1'b0;
            end
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            pattern_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (free_run)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic offer_tick(input logic [CHANNELS-1:0] levels);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = back_to_back ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        raw_levels <= levels;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer_list(input logic [CHANNELS-1:0] seq [$]);
        foreach (seq[i])
            offer_tick(seq[i]);
    endtask

    // Stops offering, then waits for every reading plus a few cycles of margin.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The unused upper data bits are randomized to show they are ignored.
    task automatic write_weight(input int ch, input int w);
        write_reg(REG_WEIGHT_ONE + CFG_IDX_W'(ch), {3'($urandom), 13'(w)});
    endtask

    task automatic write_flag(input logic [CFG_IDX_W-1:0] idx, input logic bit_val);
        write_reg(idx, {15'($urandom), bit_val});
    endtask

    task automatic configure_random(input bit extremes);
        int w;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (extremes)
                w = $urandom_range(0, 1) ? 4095 : -4096;
            else
                case ($urandom_range(0, 3))
                    0: w = -4096;
                    1: w = 4095;
                    default: w = int'($urandom_range(0, 8191)) - 4096;
                endcase
            write_weight(ch, w);
        end
        write_flag(REG_DIR_INVERT, 1'($urandom));
        write_flag(REG_ACTIVE_LEVEL, 1'($urandom));
        case ($urandom_range(0, 3))
            0: write_reg(REG_ABN_LIMIT, '0);
            1: write_reg(REG_ABN_LIMIT, CFG_DATA_W'($urandom_range(1, 10)));
            2: write_reg(REG_ABN_LIMIT, CFG_DATA_W'($urandom));
            default: write_reg(REG_ABN_LIMIT, '1);
        endcase
        if ($urandom_range(0, 1))
            write_reg(CFG_IDX_W'($urandom_range(8, 255)), CFG_DATA_W'($urandom));
    endtask

    // Mostly held patterns that get past the debounce, runs of all-off or all-on
    // that drive the abnormal counter, and some single-tick noise.
    task automatic send_random(input int n);
        logic [CHANNELS-1:0] pat;
        int left;
        int run;
        int kind;
        left = n;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                pat = CHANNELS'($urandom);
                run = $urandom_range(2, 6);
            end
            else if (kind < 8)
            begin
                pat = $urandom_range(0, 1) ? '1 : '0;
                run = $urandom_range(1, 20);
            end
            else
                run = $urandom_range(1, 4);
            for (int k = 0; k < run && left > 0; k++)
            begin
                if (kind >= 8)
                    pat = CHANNELS'($urandom);
                offer_tick(pat);
                left--;
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_levels = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        back_to_back = 0;
        free_run = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: lost, all active, single channels, pairs and triples.
        offer_list('{5'h00, 5'h00, 5'h1F, 5'h1F, 5'h01, 5'h01, 5'h10, 5'h10,
                     5'h0E, 5'h03, 5'h03, 5'h18, 5'h18});
        drain();

        // Extreme weights, inverted direction, active-low sensing, zero limit.
        write_weight(0, -4096);
        write_weight(1, -4096);
        write_weight(2, 4095);
        write_weight(3, 4095);
        write_weight(4, -1);
        write_flag(REG_DIR_INVERT, 1'b1);
        write_flag(REG_ACTIVE_LEVEL, 1'b0);
        write_reg(REG_ABN_LIMIT, '0);
        offer_list('{5'h1F, 5'h1F, 5'h00, 5'h00, 5'h1C, 5'h1C, 5'h07, 5'h07,
                     5'h16, 5'h16, 5'h18, 5'h18});
        drain();

        // Writes beyond the last register must change nothing.
        write_reg(8'd8, 16'hFFFF);
        write_reg(8'd255, 16'h5A5A);

        // Abnormal counter: with the top limit status never goes suspect, and with
        // a small limit it does once the abnormal count exceeds it.
        write_reg(REG_ABN_LIMIT, '1);
        back_to_back = 1;
        free_run = 1;
        for (int i = 0; i < ABNORMAL_RUN; i++)
            offer_tick(5'h1F);
        drain();
        write_reg(REG_ABN_LIMIT, 16'd3);
        offer_list('{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F});
        drain();
        back_to_back = 0;
        free_run = 0;

        configure_random(1'b1);
        @(posedge clk);
        hold_req <= 1'b1;
        back_to_back = 1;
        send_random(40);
        back_to_back = 0;
        send_random(160);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            configure_random(phase == 3);
            send_random(200);
            drain();
        end

        repeat (20) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d readings never arrived", tracker.pending()));
        if (tracker.mismatches == 0)
            $display("line_tracker_centroid_tb passed");
        else
            $display("line_tracker_centroid_tb failed");
        $finish;
    end

endmodule
